/* rtl/core/fdt_pkg.sv */
// Shared types, constants and opcodes for the fractional delay tap core.
package fdt_pkg;

  localparam int MAX_LINE    = 65536;
  localparam int SAMPLE_BITS = 24;
  localparam int ADDR_BITS   = 16;
  localparam int LEN_BITS    = 17;
  localparam int DELAY_BITS  = 20;
  localparam int FRAC_BITS   = 17;
  localparam int FRAC_SHIFT  = 16;
  localparam int DIV_RADIX   = 4;
  localparam int DIV_STEPS   = DELAY_BITS / DIV_RADIX;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int PROD_BITS   = DIFF_BITS + FRAC_BITS + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [FRAC_BITS-1:0] FRAC_ONE = FRAC_BITS'(65536);
  localparam logic [LEN_BITS-1:0]  LEN_MAX  = LEN_BITS'(MAX_LINE);

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic                          opcode;
    logic [ADDR_BITS-1:0]          position;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [DELAY_BITS-1:0]         delay_samples;
    logic [FRAC_BITS-1:0]          fraction;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] tap_value;
    logic                          bad_position;
  } out_word_t;

  typedef struct packed {
    logic                          is_read;
    logic [ADDR_BITS-1:0]          position;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [DELAY_BITS-1:0]         delay;
    logic [FRAC_BITS-1:0]          frac;
  } cmd_t;

endpackage

/* rtl/core/fractional_delay_tap_core.sv */
// Top level of the fractional delay tap core: front end, queue and back end.
// Store word: one per cycle while the back end is idle, written to the line at the edge that pops it.
// Read word: the result is posted after the radix-16 modulo unit and the two single-port
//   store reads; the back end pops no new word until that result is posted.
// Reset (rst, synchronous) empties the queue, clears the output and sets the
//   line length to 65536; the line store keeps its contents.
module fractional_delay_tap_core
  import fdt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_word_t            in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_word,
  input  logic                cfg_we,
  input  logic [LEN_BITS-1:0] cfg_wdata
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;
  logic q_avail;
  logic q_pop;
  cmd_t q_head;

  fdt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd)
  );

  fdt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_valid),
    .push_cmd(cmd),
    .ready   (cmd_ready),
    .pop     (q_pop),
    .avail   (q_avail),
    .head    (q_head)
  );

  fdt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_avail  (q_avail),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule

/* rtl/core/fdt_ram.sv */
// Generic single-port RAM with registered read.
module fdt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/core/fdt_front.sv */
// Front end: accepts input words, decodes the opcode and clamps the fraction.
module fdt_front
  import fdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  cmd_t cmd_next;
  logic take;

  assign in_stall = cmd_valid & ~cmd_ready;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    cmd_next.is_read  = (in_word.opcode == OP_READ);
    cmd_next.position = in_word.position;
    cmd_next.sample   = in_word.sample_in;
    cmd_next.delay    = in_word.delay_samples;
    cmd_next.frac     = (in_word.fraction > FRAC_ONE) ? FRAC_ONE : in_word.fraction;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (take) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
    if (take) begin
      cmd <= cmd_next;
    end
  end

endmodule

/* rtl/core/fdt_queue.sv */
// Two-entry command queue between front end and back end.
module fdt_queue
  import fdt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic ready,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign ready   = (count != CNT_BITS'(QUEUE_DEPTH));
  assign avail   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push & ready;
  assign do_pop  = pop & avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
    end
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* rtl/core/fdt_back.sv */
// Back end: sample store, modulo reduction, tap addressing and interpolation.
module fdt_back
  import fdt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [LEN_BITS-1:0] cfg_wdata,
  input  logic                q_avail,
  input  cmd_t                q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_word
);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_ADDR, S_RD0, S_RD1, S_DIFF, S_MUL, S_SUM
  } state_t;

  state_t                        state;
  logic [LEN_BITS-1:0]           line_length;
  logic [LEN_BITS-1:0]           len_eff;
  cmd_t                          cur;
  logic                          bad;
  logic [DELAY_BITS-1:0]         pos_sh;
  logic [DELAY_BITS-1:0]         dly_sh;
  logic [LEN_BITS-1:0]           rem_p;
  logic [LEN_BITS-1:0]           rem_d;
  logic [LEN_BITS-1:0]           rem_p_next;
  logic [LEN_BITS-1:0]           rem_d_next;
  logic [DIV_CNT_BITS-1:0]       div_cnt;
  logic [ADDR_BITS-1:0]          r0;
  logic [ADDR_BITS-1:0]          r1;
  logic [ADDR_BITS-1:0]          r0_next;
  logic [ADDR_BITS-1:0]          r1_next;
  logic [LEN_BITS:0]             addr_sum;
  logic [LEN_BITS:0]             addr_red;
  logic signed [SAMPLE_BITS-1:0] s0;
  logic signed [DIFF_BITS-1:0]   diff;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [DIFF_BITS-1:0]   tap_full;
  logic                          ram_we;
  logic [ADDR_BITS-1:0]          ram_addr;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic                          out_free;

  function automatic logic [LEN_BITS-1:0] mod_step(
    input logic [LEN_BITS-1:0] rem,
    input logic                b,
    input logic [LEN_BITS-1:0] len
  );
    logic [LEN_BITS:0] t;
    t = {rem, b};
    if (t >= {1'b0, len}) begin
      t = t - {1'b0, len};
    end
    return t[LEN_BITS-1:0];
  endfunction

  always_comb begin
    if (line_length == '0) begin
      len_eff = LEN_BITS'(1);
    end else if (line_length > LEN_MAX) begin
      len_eff = LEN_MAX;
    end else begin
      len_eff = line_length;
    end
  end

  // restoring remainder, DIV_RADIX bits per cycle for both operands
  always_comb begin
    rem_p_next = rem_p;
    rem_d_next = rem_d;
    for (int i = 0; i < DIV_RADIX; i++) begin
      rem_p_next = mod_step(rem_p_next, pos_sh[DELAY_BITS-1-i], len_eff);
      rem_d_next = mod_step(rem_d_next, dly_sh[DELAY_BITS-1-i], len_eff);
    end
  end

  always_comb begin
    addr_sum = {1'b0, rem_p} + {1'b0, len_eff} - {1'b0, rem_d};
    addr_red = (addr_sum >= {1'b0, len_eff}) ? addr_sum - {1'b0, len_eff} : addr_sum;
    r0_next  = addr_red[ADDR_BITS-1:0];
    r1_next  = (r0_next == '0) ? ADDR_BITS'(len_eff - 1'b1) : r0_next - 1'b1;
  end

  assign q_pop    = (state == S_IDLE) & q_avail;
  assign ram_we   = q_pop & ~q_head.is_read;
  assign out_free = ~out_valid | ~out_stall;
  assign tap_full = DIFF_BITS'(s0) + prod[FRAC_SHIFT+DIFF_BITS-1:FRAC_SHIFT];

  always_comb begin
    case (state)
      S_RD0:   ram_addr = r0;
      S_RD1:   ram_addr = r1;
      default: ram_addr = q_head.position;
    endcase
  end

  fdt_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_LINE)
  ) u_line_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(q_head.sample),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      line_length <= LEN_MAX;
    end else begin
      if (cfg_we) begin
        line_length <= cfg_wdata;
      end
      if ((state == S_SUM) && out_free) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_avail & q_head.is_read) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
            state <= S_ADDR;
          end
        end
        S_ADDR: state <= S_RD0;
        S_RD0:  state <= S_RD1;
        S_RD1:  state <= S_DIFF;
        S_DIFF: state <= S_MUL;
        S_MUL:  state <= S_SUM;
        S_SUM: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end

    case (state)
      S_IDLE: begin
        cur     <= q_head;
        bad     <= ({1'b0, q_head.position} >= len_eff);
        pos_sh  <= DELAY_BITS'(q_head.position);
        dly_sh  <= q_head.delay;
        rem_p   <= '0;
        rem_d   <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        rem_p   <= rem_p_next;
        rem_d   <= rem_d_next;
        pos_sh  <= pos_sh << DIV_RADIX;
        dly_sh  <= dly_sh << DIV_RADIX;
        div_cnt <= div_cnt + 1'b1;
      end
      S_ADDR: begin
        r0 <= r0_next;
        r1 <= r1_next;
      end
      S_RD1:  s0 <= ram_rdata;
      S_DIFF: diff <= DIFF_BITS'($signed(ram_rdata)) - DIFF_BITS'(s0);
      S_MUL:  prod <= $signed({1'b0, cur.frac}) * diff;
      S_SUM: begin
        if (out_free) begin
          out_word.tap_value    <= tap_full[SAMPLE_BITS-1:0];
          out_word.bad_position <= bad;
        end
      end
      default: ;
    endcase
  end

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM) && out_free |=> out_valid)
    else $error("result not posted");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADDR) |-> (rem_p < len_eff) && (rem_d < len_eff))
    else $error("remainder out of range");

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD0) |-> ({1'b0, r0} < len_eff) && ({1'b0, r1} < len_eff))
    else $error("tap address beyond line length");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE) && q_avail)
    else $error("queue popped while busy");

endmodule

/* sim/fractional_delay_tap_core_tb.sv */
// Testbench for fractional_delay_tap_core: store/read words against a line model.
`timescale 1ns / 1ps

import fdt_pkg::*;

class tap_scoreboard;
  logic signed [SAMPLE_BITS-1:0] line_mem [MAX_LINE];
  logic [LEN_BITS-1:0] line_len = LEN_MAX;
  out_word_t tap_queue [$];
  int errors;

  function int unsigned span();
    int unsigned n;
    n = line_len;
    if (n == 0) n = 1;
    if (n > MAX_LINE) n = MAX_LINE;
    return n;
  endfunction

  function void taps(input logic [ADDR_BITS-1:0] pos, input logic [DELAY_BITS-1:0] dly,
                     output int unsigned r0, output int unsigned r1);
    int unsigned n;
    n = span();
    r0 = pos % n + n - dly % n;
    if (r0 >= n) r0 -= n;
    r1 = (r0 == 0) ? n - 1 : r0 - 1;
  endfunction

  function void note_input(in_word_t w);
    int unsigned r0, r1;
    longint s0, s1, f;
    out_word_t want;
    if (w.opcode == OP_STORE) begin
      line_mem[w.position] = w.sample_in;
      return;
    end
    taps(w.position, w.delay_samples, r0, r1);
    s0 = line_mem[r0];
    s1 = line_mem[r1];
    f = (w.fraction > FRAC_ONE) ? longint'(FRAC_ONE) : longint'(w.fraction);
    want.tap_value = SAMPLE_BITS'(s0 + ((f * (s1 - s0)) >>> FRAC_SHIFT));
    want.bad_position = (w.position >= span());
    tap_queue.push_back(want);
  endfunction

  function void check_result(out_word_t got);
    out_word_t want;
    if (tap_queue.size() == 0) begin
      errors++;
      $display("%0t: result with none expected: tap_value=%0d bad_position=%0b",
               $time, got.tap_value, got.bad_position);
      return;
    end
    want = tap_queue.pop_front();
    if (got.tap_value !== want.tap_value) begin
      errors++;
      $display("%0t: tap_value expected %0d actual %0d",
               $time, want.tap_value, got.tap_value);
    end
    if (got.bad_position !== want.bad_position) begin
      errors++;
      $display("%0t: bad_position expected %0b actual %0b",
               $time, want.bad_position, got.bad_position);
    end
  endfunction
endclass

module fractional_delay_tap_core_tb;
  localparam int IDLE_PCT      = 18;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 500000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  in_word_t            in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_word_t           out_word;
  logic                cfg_we = 1'b0;
  logic [LEN_BITS-1:0] cfg_wdata = '0;

  tap_scoreboard sb;
  bit        seeded [MAX_LINE];
  bit        in_gaps_on = 1'b1;
  bit        out_gaps_on = 1'b1;
  int        holds_asked = 0;
  int        holds_given = 0;
  int        hold_left = 0;
  int        cycle_count = 0;
  bit        res_take;
  out_word_t res_word;

  fractional_delay_tap_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stall: random, plus a long hold on request
  always @(posedge clk) begin
    if (holds_asked != holds_given) begin
      holds_given <= holds_asked;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= out_gaps_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always begin
    @(negedge clk);
    res_take = out_valid && !out_stall && !rst;
    res_word = out_word;
    @(posedge clk);
    if (res_take) sb.check_result(res_word);
  end

  task automatic send_word(input in_word_t w);
    bit go;
    while (in_gaps_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    if (w.opcode == OP_STORE) seeded[w.position] = 1'b1;
    in_valid <= 1'b1;
    in_word <= w;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
    sb.note_input(w);
  endtask

  task automatic send_fields(input logic op, input int pos, input int sample,
                             input int dly, input int frac);
    in_word_t w;
    w.opcode = op;
    w.position = ADDR_BITS'(pos);
    w.sample_in = SAMPLE_BITS'(sample);
    w.delay_samples = DELAY_BITS'(dly);
    w.fraction = FRAC_BITS'(frac);
    send_word(w);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.tap_queue.size() != 0);
  endtask

  task automatic set_length(input logic [LEN_BITS-1:0] v);
    drain_results();
    // store words leave no result; give the block time to finish them
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.line_len = v;
  endtask

  // a read must only touch entries already written
  task automatic seed_entry(input int unsigned idx, inout int sent);
    if (!seeded[idx]) begin
      send_fields(OP_STORE, idx, $urandom, $urandom, $urandom);
      sent++;
    end
  endtask

  task automatic directed_items();
    send_fields(OP_STORE, 0, 8388607, 20'hFFFFF, 131071);
    send_fields(OP_STORE, 65535, -8388608, 0, 0);
    send_fields(OP_STORE, 1, 0, 0, 0);
    send_fields(OP_STORE, 2, -1, 0, 0);
    send_fields(OP_STORE, 3, 0, 0, 0);
    send_fields(OP_STORE, 32768, 24'h555555, 0, 0);
    send_fields(OP_STORE, 32767, 24'hAAAAAA, 0, 0);
    send_fields(OP_STORE, 65534, 12345, 0, 0);
    send_fields(OP_READ, 0, 24'h7FFFFF, 0, 0);
    send_fields(OP_READ, 0, 24'h800000, 0, 65536);
    send_fields(OP_READ, 0, 0, 0, 65537);
    send_fields(OP_READ, 0, -1, 0, 131071);
    send_fields(OP_READ, 0, 0, 0, 32768);
    send_fields(OP_READ, 1, 0, 0, 1);
    send_fields(OP_READ, 2, 0, 0, 1);
    send_fields(OP_READ, 3, 0, 0, 1);
    send_fields(OP_READ, 0, 0, 1048575, 65535);
    send_fields(OP_READ, 32768, 0, 0, 65535);
    send_fields(OP_READ, 65535, 0, 65535, 40000);
  endtask

  // count covers the seeding stores as well
  task automatic random_items(input int count);
    in_word_t w;
    int unsigned r0, r1;
    int sent;
    sent = 0;
    while (sent < count) begin
      w.opcode = ($urandom_range(99) < 40) ? OP_STORE : OP_READ;
      if ($urandom_range(1) && sb.span() < MAX_LINE)
        w.position = ADDR_BITS'($urandom_range(sb.span() - 1));
      else
        w.position = ADDR_BITS'($urandom);
      w.sample_in = SAMPLE_BITS'($urandom);
      if ($urandom_range(3) == 0)
        w.delay_samples = DELAY_BITS'($urandom_range(4));
      else
        w.delay_samples = DELAY_BITS'($urandom);
      case ($urandom_range(9))
        0: w.fraction = '0;
        1: w.fraction = FRAC_ONE;
        2, 3: w.fraction = FRAC_BITS'($urandom_range(131071, 65537));
        default: w.fraction = FRAC_BITS'($urandom_range(65536));
      endcase
      if (w.opcode == OP_READ) begin
        sb.taps(w.position, w.delay_samples, r0, r1);
        seed_entry(r0, sent);
        seed_entry(r1, sent);
      end
      send_word(w);
      sent++;
    end
  endtask

  initial begin
    sb = new;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_items();

    set_length(LEN_MAX);
    random_items(120);
    holds_asked++;
    random_items(60);
    drain_results();
    random_items(40);

    set_length(LEN_BITS'(1));
    random_items(110);
    set_length('0);
    random_items(100);
    set_length(LEN_BITS'(2));
    random_items(110);

    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    set_length('1);
    random_items(150);
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;

    set_length(LEN_BITS'(65535));
    random_items(110);
    set_length(LEN_BITS'(3));
    random_items(100);
    set_length(LEN_BITS'($urandom_range(300, 4)));
    random_items(110);
    set_length(LEN_BITS'($urandom_range(65534, 300)));
    random_items(110);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.tap_queue.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

/* fractional_delay_tap_core.f */
rtl/core/fdt_pkg.sv
rtl/core/fdt_ram.sv
rtl/core/fdt_front.sv
rtl/core/fdt_queue.sv
rtl/core/fdt_back.sv
rtl/core/fractional_delay_tap_core.sv
sim/fractional_delay_tap_core_tb.sv
